// ----- rtl/tpf_pkg.sv -----
// ---------------------------------------------------------------------------
// tpf_pkg
// Shared types and constants of the timed pin fade controller.
// ---------------------------------------------------------------------------
package tpf_pkg;

	localparam int NCH      = 16;              // channels in the bank
	localparam int CH_W     = 4;
	localparam int LIM_W    = 5;               // holds 0..NCH
	localparam int FADE_MS  = 1000;            // fade length, ms
	localparam int MS_PER_S = 1000;
	localparam int LEN_W    = 26;              // timer length, ms
	localparam int TIME_W   = 32;
	localparam int BYTE_MAX = 255;

	// fade interpolation: elapsed * delta, then floor divide by FADE_MS
	localparam int EL_W   = $clog2(FADE_MS);
	localparam int PROD_W = EL_W + 10;
	localparam int REC_SH = PROD_W + 2 * EL_W;
	localparam longint unsigned REC_VAL =
		((64'd1 << REC_SH) + longint'(FADE_MS) - 1) / longint'(FADE_MS);
	localparam int REC_W = PROD_W + EL_W + 1;
	localparam logic [REC_W-1:0] FADE_RECIP = REC_VAL[REC_W-1:0];

	typedef enum logic [2:0] {
		OP_TICK     = 3'd0,
		OP_DIG_SET  = 3'd1,
		OP_DIG_TMD  = 3'd2,
		OP_PWM_SET  = 3'd3,
		OP_PWM_TMD  = 3'd4,
		OP_FADE     = 3'd5,
		OP_FADE_HLD = 3'd6,
		OP_STATUS   = 3'd7
	} op_t;

	typedef enum logic [1:0] {
		MODE_DIG  = 2'd0,
		MODE_PWM  = 2'd1,
		MODE_FADE = 2'd2
	} mode_t;

	localparam logic [1:0] KIND_NONE = 2'd0;
	localparam logic [1:0] KIND_DIG  = 2'd1;
	localparam logic [1:0] KIND_PWM  = 2'd2;

	typedef struct packed {
		mode_t             mode;
		logic [7:0]        value;
		logic              active;
		logic [TIME_W-1:0] start;
		logic [LEN_W-1:0]  length;
		logic [7:0]        revert;
		logic [7:0]        fade_from;
		logic [7:0]        fade_to;
		logic              hold;
		logic [TIME_W-1:0] fade_begin;
		logic              notify;
	} chan_t;

	typedef struct packed {
		logic [CH_W-1:0] ch;
		logic [1:0]      kind;
		logic [7:0]      drive;
		logic            done;
		logic [1:0]      mode;
		logic [7:0]      value;
		logic            nm;
	} res_t;

	function automatic logic [7:0] clamp_byte(input logic signed [15:0] v);
		logic [7:0] r;
		if (v < 16'sd0)
			r = 8'd0;
		else if (v > 16'sd255)
			r = 8'(BYTE_MAX);
		else
			r = v[7:0];
		return r;
	endfunction

endpackage

// ----- rtl/tpf_cmd_if.sv -----
// ---------------------------------------------------------------------------
// tpf_cmd_if
// Command channel: valid/ready with one command beat.
// ---------------------------------------------------------------------------
interface tpf_cmd_if;
	logic               valid;
	logic               ready;
	logic [2:0]         operation;
	logic [3:0]         channel;
	logic               level;
	logic signed [15:0] pwm_value;
	logic signed [15:0] finish_value;
	logic [15:0]        delay_seconds;
	logic               notify;

	modport source (output valid, operation, channel, level, pwm_value, finish_value,
		delay_seconds, notify, input ready);
	modport sink (input valid, operation, channel, level, pwm_value, finish_value,
		delay_seconds, notify, output ready);
endinterface

// ----- rtl/tpf_res_if.sv -----
// ---------------------------------------------------------------------------
// tpf_res_if
// Result channel: valid/ready with one result beat.
// ---------------------------------------------------------------------------
interface tpf_res_if;
	logic       valid;
	logic       ready;
	logic [3:0] out_channel;
	logic [1:0] write_kind;
	logic [7:0] drive_value;
	logic       done_event;
	logic [1:0] mode_report;
	logic [7:0] value_report;
	logic       not_managed;
	logic       last;

	modport source (output valid, out_channel, write_kind, drive_value, done_event,
		mode_report, value_report, not_managed, last, input ready);
	modport sink (input valid, out_channel, write_kind, drive_value, done_event,
		mode_report, value_report, not_managed, last, output ready);
endinterface

// ----- rtl/timed_pin_fade_controller.sv -----
// ---------------------------------------------------------------------------
// timed_pin_fade_controller
// Channel bank with digital/pwm outputs, timed reverts and linear fades.
// ---------------------------------------------------------------------------
//  channel | dir | handshake         | beat
//  cmd     | in  | valid/ready       | one command or tick
//  res     | out | valid/ready       | one pin write or status reply
//  cfg     | in  | cfg_we/cfg_wdata  | channels_in_use, no read-back
//
//  Command or status: read, modify/write, hand to output.
//  Tick: per managed channel, the loop of read, multiply, reciprocal
//  divide and write-back on the state RAM.
//  Reset clears the ms counter, control and the per-entry valid bits;
//  an entry never written reads as all zero, so no clearing pass is needed.
//  The output register lets a new command in while a result waits; a stalled
//  output holds the scan at its next pin write.
// ---------------------------------------------------------------------------
module timed_pin_fade_controller
	import tpf_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	tpf_cmd_if.sink           cmd,
	tpf_res_if.source         res,
	input  logic              cfg_we,
	input  logic [LIM_W-1:0]  cfg_wdata
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_SCAN_RD,
		S_SCAN_EV,
		S_SCAN_DV,
		S_SCAN_WB,
		S_CMD_EV,
		S_FLUSH
	} state_t;

	typedef struct packed {
		op_t               op;
		logic [CH_W-1:0]   ch;
		logic              lvl;
		logic signed [15:0] pv;
		logic signed [15:0] fv;
		logic [15:0]       secs;
		logic              ntf;
	} cmd_t;

	state_t            state_q;
	cmd_t              cmd_q;
	logic [LIM_W-1:0]  cfg_q;
	logic [TIME_W-1:0] now_q;
	logic [LIM_W-1:0]  idx_q;
	logic [NCH-1:0]    vld_q;
	logic [CH_W-1:0]   rd_addr_q;

	// staged result: the last beat of a scan is only known at its end
	res_t              stg_q;
	logic              stg_valid_q;
	res_t              out_q;
	logic              out_last_q;
	logic              out_valid_q;

	chan_t             ent_s1;
	logic signed [PROD_W-1:0] prod_s1;
	logic [7:0]        quo_s2;
	logic              neg_s2;

	logic [CH_W-1:0]   rd_addr;
	logic [$bits(chan_t)-1:0] ram_rdata;
	chan_t             ent;
	logic              ram_we;
	logic [CH_W-1:0]   ram_waddr;
	chan_t             ram_wdata;

	logic [LIM_W-1:0]  lim;
	logic              in_acc;
	logic              out_free;
	logic              out_load;
	logic              cmd_managed;

	// ---- state RAM, one entry per channel ----
	tpf_ram #(
		.WIDTH ($bits(chan_t)),
		.DEPTH (NCH)
	) u_state_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (rd_addr),
		.rdata (ram_rdata)
	);

	assign lim         = (cfg_q > LIM_W'(NCH)) ? LIM_W'(NCH) : cfg_q;
	assign cmd.ready   = (state_q == S_IDLE);
	assign in_acc      = cmd.valid && cmd.ready;
	assign out_free    = !out_valid_q || res.ready;
	assign cmd_managed = {1'b0, cmd_q.ch} < lim;
	assign rd_addr     = (state_q == S_IDLE) ? cmd.channel : idx_q[CH_W-1:0];
	assign ent         = vld_q[rd_addr_q] ? chan_t'(ram_rdata) : '0;

	// ---- fade interpolation, first half: elapsed * (to - from) ----
	logic [TIME_W-1:0]   ev_el;
	logic signed [8:0]   ev_delta;
	assign ev_el    = now_q - ent.fade_begin;
	assign ev_delta = $signed({1'b0, ent.fade_to}) - $signed({1'b0, ent.fade_from});

	// ---- second half: floor divide by FADE_MS via reciprocal ----
	logic                dv_neg;
	logic [PROD_W-1:0]   dv_mag;
	logic [PROD_W-1:0]   dv_num;
	logic [PROD_W+REC_W-1:0] dv_full;
	assign dv_neg  = prod_s1 < 0;
	assign dv_mag  = dv_neg ? PROD_W'(-prod_s1) : PROD_W'(prod_s1);
	// negative quotient rounds away from zero on the magnitude
	assign dv_num  = dv_neg ? dv_mag + PROD_W'(FADE_MS - 1) : dv_mag;
	assign dv_full = (PROD_W+REC_W)'(dv_num) * (PROD_W+REC_W)'(FADE_RECIP);

	// ---- scan write-back: timer and fade evaluation ----
	chan_t             sc_new;
	res_t              sc_res;
	logic              sc_emit;
	logic              sc_stall;
	logic              hold_exp;
	logic              fade_end;
	logic [7:0]        interp;

	assign hold_exp = (now_q - ent_s1.start) >= TIME_W'(ent_s1.length);
	assign fade_end = (now_q - ent_s1.fade_begin) >= TIME_W'(ent_s1.length);
	assign interp   = ent_s1.fade_from + (neg_s2 ? (8'd0 - quo_s2) : quo_s2);

	always_comb begin
		sc_new  = ent_s1;
		sc_emit = 1'b0;
		sc_res  = '0;
		sc_res.ch = idx_q[CH_W-1:0];
		if (ent_s1.active) begin
			if (ent_s1.mode == MODE_FADE && ent_s1.hold) begin
				// holding: keep writing the start value until the hold runs out
				if (hold_exp) begin
					sc_new.hold       = 1'b0;
					sc_new.fade_begin = now_q;
					sc_new.length     = LEN_W'(FADE_MS);
				end
				sc_emit      = 1'b1;
				sc_res.kind  = KIND_PWM;
				sc_res.drive = ent_s1.fade_from;
			end else if (ent_s1.mode == MODE_FADE) begin
				sc_emit     = 1'b1;
				sc_res.kind = KIND_PWM;
				if (fade_end) begin
					sc_new.notify = 1'b0;
					sc_new.value  = ent_s1.fade_to;
					sc_new.mode   = MODE_PWM;
					sc_new.active = 1'b0;
					sc_res.drive  = ent_s1.fade_to;
					sc_res.done   = ent_s1.notify;
				end else begin
					sc_res.drive  = interp;
				end
			end else if (hold_exp) begin
				// revert timer ran out
				sc_new.active = 1'b0;
				sc_new.notify = 1'b0;
				sc_new.value  = ent_s1.revert;
				sc_emit       = 1'b1;
				sc_res.kind   = (ent_s1.mode == MODE_DIG) ? KIND_DIG : KIND_PWM;
				sc_res.drive  = ent_s1.revert;
				sc_res.done   = ent_s1.notify;
			end
		end
		sc_res.mode  = sc_new.mode;
		sc_res.value = sc_new.value;
	end

	assign sc_stall = sc_emit && stg_valid_q && !out_free;

	// staged beat moves to the output register
	assign out_load = (state_q == S_SCAN_WB && !sc_stall && sc_emit && stg_valid_q) ||
		(state_q == S_FLUSH && stg_valid_q && out_free);

	// ---- command evaluation ----
	chan_t             cm_new;
	res_t              cm_res;
	logic [7:0]        cm_pv;
	logic [LEN_W-1:0]  cm_len;

	assign cm_pv  = clamp_byte(cmd_q.pv);
	assign cm_len = LEN_W'(cmd_q.secs) * LEN_W'(MS_PER_S);

	always_comb begin
		cm_new = ent;
		cm_res = '0;
		cm_res.ch = cmd_q.ch;
		case (cmd_q.op)
			OP_DIG_SET, OP_DIG_TMD: begin
				cm_new.mode  = MODE_DIG;
				cm_new.value = {7'd0, cmd_q.lvl};
				if (cmd_q.op == OP_DIG_SET) begin
					cm_new.active = 1'b0;
					cm_new.notify = 1'b0;
				end else begin
					cm_new.active = 1'b1;
					cm_new.start  = now_q;
					cm_new.length = cm_len;
					cm_new.revert = {7'd0, !cmd_q.lvl};
					cm_new.notify = cmd_q.ntf;
				end
				cm_res.kind  = KIND_DIG;
				cm_res.drive = {7'd0, cmd_q.lvl};
			end
			OP_PWM_SET, OP_PWM_TMD: begin
				cm_new.mode  = MODE_PWM;
				cm_new.value = cm_pv;
				if (cmd_q.op == OP_PWM_SET) begin
					cm_new.active = 1'b0;
					cm_new.notify = 1'b0;
				end else begin
					cm_new.active = 1'b1;
					cm_new.start  = now_q;
					cm_new.length = cm_len;
					cm_new.revert = (cm_pv == 8'd0) ? 8'(BYTE_MAX) : 8'd0;
					cm_new.notify = cmd_q.ntf;
				end
				cm_res.kind  = KIND_PWM;
				cm_res.drive = cm_pv;
			end
			OP_FADE, OP_FADE_HLD: begin
				cm_new.mode      = MODE_FADE;
				cm_new.active    = 1'b1;
				cm_new.start     = now_q;
				cm_new.fade_from = cm_pv;
				cm_new.fade_to   = clamp_byte(cmd_q.fv);
				cm_new.value     = cm_pv;
				if (cmd_q.op == OP_FADE) begin
					cm_new.length     = LEN_W'(FADE_MS);
					cm_new.hold       = 1'b0;
					cm_new.fade_begin = now_q;
				end else begin
					cm_new.length     = cm_len;
					cm_new.hold       = 1'b1;
					cm_new.fade_begin = '0;
					cm_new.notify     = cmd_q.ntf;
				end
				cm_res.kind  = KIND_PWM;
				cm_res.drive = cm_pv;
			end
			default: begin
				// status reply, also for tick codes that never get here
				cm_res.kind = KIND_NONE;
				cm_res.nm   = !cmd_managed;
			end
		endcase
		if (cm_res.nm) begin
			cm_res.mode  = 2'd0;
			cm_res.value = 8'd0;
		end else begin
			cm_res.mode  = cm_new.mode;
			cm_res.value = cm_new.value;
		end
	end

	// ---- RAM write port ----
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = idx_q[CH_W-1:0];
		ram_wdata = sc_new;
		if (state_q == S_SCAN_WB && !sc_stall) begin
			ram_we = 1'b1;
		end else if (state_q == S_CMD_EV && cmd_q.op != OP_STATUS) begin
			ram_we    = 1'b1;
			ram_waddr = cmd_q.ch;
			ram_wdata = cm_new;
		end
	end

	// ---- control ----
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			cfg_q       <= LIM_W'(NCH);
			now_q       <= '0;
			idx_q       <= '0;
			vld_q       <= '0;
			stg_valid_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we)
				cfg_q <= cfg_wdata;
			if (ram_we)
				vld_q[ram_waddr] <= 1'b1;
			if (out_load)
				out_valid_q <= 1'b1;
			else if (out_free)
				out_valid_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (in_acc) begin
						if (op_t'(cmd.operation) == OP_TICK) begin
							now_q   <= now_q + TIME_W'(1);
							idx_q   <= '0;
							state_q <= S_SCAN_RD;
						end else if (op_t'(cmd.operation) == OP_STATUS ||
								{1'b0, cmd.channel} < lim) begin
							state_q <= S_CMD_EV;
						end
					end
				end
				S_SCAN_RD: begin
					state_q <= (idx_q < lim) ? S_SCAN_EV : S_FLUSH;
				end
				S_SCAN_EV: state_q <= S_SCAN_DV;
				S_SCAN_DV: state_q <= S_SCAN_WB;
				S_SCAN_WB: begin
					if (!sc_stall) begin
						if (sc_emit)
							stg_valid_q <= 1'b1;
						idx_q   <= idx_q + LIM_W'(1);
						state_q <= S_SCAN_RD;
					end
				end
				S_CMD_EV: begin
					stg_valid_q <= 1'b1;
					state_q     <= S_FLUSH;
				end
				S_FLUSH: begin
					if (!stg_valid_q) begin
						state_q <= S_IDLE;
					end else if (out_free) begin
						stg_valid_q <= 1'b0;
						state_q     <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// ---- datapath registers ----
	always_ff @(posedge clk) begin
		rd_addr_q <= rd_addr;
		if (in_acc) begin
			cmd_q.op   <= op_t'(cmd.operation);
			cmd_q.ch   <= cmd.channel;
			cmd_q.lvl  <= cmd.level;
			cmd_q.pv   <= cmd.pwm_value;
			cmd_q.fv   <= cmd.finish_value;
			cmd_q.secs <= cmd.delay_seconds;
			cmd_q.ntf  <= cmd.notify;
		end
		if (state_q == S_SCAN_EV) begin
			ent_s1  <= ent;
			prod_s1 <= $signed({{(PROD_W-EL_W){1'b0}}, ev_el[EL_W-1:0]}) *
				PROD_W'(ev_delta);
		end
		if (state_q == S_SCAN_DV) begin
			quo_s2 <= dv_full[REC_SH +: 8];
			neg_s2 <= dv_neg;
		end
		if (state_q == S_SCAN_WB && !sc_stall && sc_emit) begin
			stg_q <= sc_res;
			if (stg_valid_q) begin
				out_q      <= stg_q;
				out_last_q <= 1'b0;
			end
		end
		if (state_q == S_CMD_EV)
			stg_q <= cm_res;
		if (state_q == S_FLUSH && stg_valid_q && out_free) begin
			out_q      <= stg_q;
			out_last_q <= 1'b1;
		end
	end

	assign res.valid        = out_valid_q;
	assign res.out_channel  = out_q.ch;
	assign res.write_kind   = out_q.kind;
	assign res.drive_value  = out_q.drive;
	assign res.done_event   = out_q.done;
	assign res.mode_report  = out_q.mode;
	assign res.value_report = out_q.value;
	assign res.not_managed  = out_q.nm;
	assign res.last         = out_last_q;

	// ---- assertions ----
	a_no_stage_on_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc |-> !stg_valid_q)
		else $error("command accepted with a result still staged");

	a_write_managed: assert property (@(posedge clk) disable iff (!arst_n)
		ram_we |-> ({1'b0, ram_waddr} < lim))
		else $error("state write to an unmanaged channel");

	a_time_only_on_tick: assert property (@(posedge clk) disable iff (!arst_n)
		!(in_acc && op_t'(cmd.operation) == OP_TICK) |=> $stable(now_q))
		else $error("ms counter moved without a tick");

endmodule

// ----- rtl/tpf_ram.sv -----
// ---------------------------------------------------------------------------
// tpf_ram
// Generic single write, single read RAM with registered read data.
// ---------------------------------------------------------------------------
module tpf_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we)
			mem[waddr] <= wdata;
		rdata <= mem[raddr];
	end
endmodule
